// ===== hw/rtl/stpr_pkg.sv =====
// Package for the screen-to-printer rotator.
// Holds the screen geometry, printer row constants, command codes and the
// memory request type shared by the top level and the bitmap store.
package stpr_pkg;

  // Screen bitmap geometry
  localparam int unsigned ScreenBytes = 6144;
  localparam int unsigned Lanes       = 4;                  // rows per printer byte
  localparam int unsigned MemDepth    = ScreenBytes / Lanes;
  localparam int unsigned MemAw       = $clog2(MemDepth);

  // Printer row layout
  localparam int unsigned LastGroup  = 47;
  localparam int unsigned HalfNoPad  = 48;
  localparam int unsigned HalfPad    = 50;
  localparam int unsigned RowNoPad   = 96;
  localparam int unsigned RowPad     = 100;
  localparam logic [7:0]  HeaderByte = 8'h04;

  // Configuration register indexes
  localparam logic RegPadMode = 1'b0;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  // Request to the banked bitmap store
  typedef struct packed {
    logic             en;
    logic             we;
    logic [1:0]       lane;
    logic [MemAw-1:0] addr;
  } mem_req_t;

endpackage

// ===== hw/rtl/stpr_mem.sv =====
// Banked screen bitmap store: one word holds the four screen bytes of four
// vertically adjacent rows, written one byte lane at a time. Uses stpr_pkg.
module stpr_mem import stpr_pkg::*; (
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  input  logic [7:0]            wdata_i,
  output logic [Lanes-1:0][7:0] rdata_o
);

  logic [Lanes-1:0][7:0] mem_q [MemDepth];
  logic [Lanes-1:0][7:0] rdata_q;

  // Byte-lane write, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem_q[req_i.addr][req_i.lane] <= wdata_i;
      end else begin
        rdata_q <= mem_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/screen_to_printer_rotate.sv =====
// Screen-to-printer rotator: banked 256x192 screen bitmap, printer byte reads.
// Throughput: one item per cycle, loads and reads alike; busy stays low and
// the receiver cannot stall, so nothing ever holds an item off.
// Reads: the memory read word is registered, then the assembled byte is
// registered as the result; a load gives no result.
// Reset: pad_mode clears to 0 and the result pipeline empties; the bitmap is
// not cleared and holds no defined value until written.
module screen_to_printer_rotate import stpr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item channel
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [12:0] screen_address_i,
  input  logic [7:0]  screen_data_i,
  input  logic [7:0]  column_i,
  input  logic [6:0]  byte_position_i,
  // Results
  output logic        result_valid_o,
  output logic [7:0]  printer_byte_o,
  output logic        out_of_range_o,
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic pad_mode_q;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegPadMode)) begin
      pad_mode_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == RegPadMode) ? {31'd0, pad_mode_q} : 32'd0;

  // Item decode
  logic     accept;
  logic     is_read;
  logic     is_load;
  mem_req_t mem_req;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_read = accept && (cmd_e'(cmd_i) == CMD_READ);
  assign is_load = accept && (cmd_e'(cmd_i) == CMD_LOAD);

  // Printer position to row group
  logic [6:0] row_len;
  logic [6:0] half_len;
  logic       oor;
  logic [6:0] pos_in_half;
  logic       hdr;
  logic [5:0] group;
  logic [5:0] yhi;
  logic [MemAw-1:0] rd_addr;
  logic [MemAw-1:0] wr_addr;

  always_comb begin
    row_len     = pad_mode_q ? 7'(RowPad) : 7'(RowNoPad);
    half_len    = pad_mode_q ? 7'(HalfPad) : 7'(HalfNoPad);
    oor         = byte_position_i >= row_len;
    pos_in_half = (byte_position_i >= half_len) ? (byte_position_i - half_len)
                                                : byte_position_i;
    hdr         = pad_mode_q && (pos_in_half < 7'd2);
    group       = pos_in_half[5:0] - {4'd0, pad_mode_q, 1'b0};
    yhi         = 6'(LastGroup) - group;   // row bits [7:2] of the lowest row
    // Interleaved layout: {y[7:6], y[2], y[5:3], x[7:3]}, lane = y[1:0]
    rd_addr     = {yhi[5:4], yhi[0], yhi[3:1], column_i[7:3]};
    wr_addr     = {screen_address_i[12:10], screen_address_i[7:0]};
  end

  always_comb begin
    mem_req.en   = is_read || (is_load && (screen_address_i < 13'(ScreenBytes)));
    mem_req.we   = is_load;
    mem_req.lane = screen_address_i[9:8];
    mem_req.addr = is_load ? wr_addr : rd_addr;
  end

  logic [Lanes-1:0][7:0] rdata;

  stpr_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .wdata_i (screen_data_i),
    .rdata_o (rdata)
  );

  // Stage 1: alongside the memory read
  logic       s1_valid_q;
  logic       s1_oor_q;
  logic       s1_hdr_q;
  logic       s1_hdr_first_q;
  logic [2:0] s1_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_read) begin
      s1_oor_q       <= oor;
      s1_hdr_q       <= hdr;
      s1_hdr_first_q <= (pos_in_half == 7'd0);
      s1_bit_q       <= 3'd7 - column_i[2:0];
    end
  end

  // Stage 2: assemble the doubled pixel pairs, or a zero or header byte for out-of-range and pad positions
  logic [7:0] byte_d;

  always_comb begin
    byte_d = 8'd0;
    for (int k = 0; k < Lanes; k++) begin
      byte_d[2*k +: 2] = {2{rdata[k][s1_bit_q]}};
    end
    if (s1_oor_q) begin
      byte_d = 8'd0;
    end else if (s1_hdr_q) begin
      byte_d = s1_hdr_first_q ? HeaderByte : 8'd0;
    end
  end

  logic       res_valid_q;
  logic [7:0] res_byte_q;
  logic       res_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_byte_q <= byte_d;
      res_oor_q  <= s1_oor_q;
    end
  end

  assign result_valid_o = res_valid_q;
  assign printer_byte_o = res_byte_q;
  assign out_of_range_o = res_oor_q;

  // Checks
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_read |=> ##1 result_valid_o)
    else $error("read item lost its result");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_e'(cmd_i) == CMD_LOAD)) |=> ##1 !result_valid_o)
    else $error("load item produced a result");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_of_range_o) |-> (printer_byte_o == 8'd0))
    else $error("out-of-range result with non-zero byte");

endmodule
